[design/ppu_pkg.sv]
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared types and constants of the particle pool update block.
// ----------------------------------------------------------------------------
package ppu_pkg;

    localparam int POOL_SIZE = 1024;
    localparam int ADDR_W    = $clog2(POOL_SIZE);
    localparam int SLOT_W    = 10;
    localparam int CNT_W     = 11;
    localparam int PADDR_W   = 5;

    localparam logic [1:0] CMD_EMIT   = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [2:0] REG_BEGIN_SCALE     = 3'd0;
    localparam logic [2:0] REG_END_SCALE       = 3'd1;
    localparam logic [2:0] REG_SCALE_VARIATION = 3'd2;
    localparam logic [2:0] REG_VELOCITY_SPREAD = 3'd3;
    localparam logic [2:0] REG_EMIT_COLOR      = 3'd4;
    localparam logic [2:0] REG_EMIT_LIFETIME   = 3'd5;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [23:0]        time_step;
        logic [9:0]         slot_index;
        logic [15:0]        jitter_scale;
        logic [15:0]        jitter_vx;
        logic [15:0]        jitter_vy;
    } t_in_item;

    typedef struct packed {
        logic [9:0]         slot;
        logic               is_active;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic [15:0]        out_begin_scale;
        logic [15:0]        out_end_scale;
        logic [23:0]        out_color;
        logic signed [31:0] life_left;
        logic [30:0]        life_total;
        logic [10:0]        active_count;
    } t_out_item;

    typedef struct packed {
        logic [15:0] begin_scale;
        logic [15:0] end_scale;
        logic [15:0] scale_variation;
        logic [30:0] velocity_spread;
        logic [23:0] emit_color;
        logic [30:0] emit_lifetime;
    } t_cfg;

    typedef struct packed {
        logic               active;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [15:0]        begin_scale;
        logic [15:0]        end_scale;
        logic [23:0]        color;
        logic signed [31:0] life_left;
        logic [30:0]        life_total;
    } t_slot;

endpackage

[design/particle_pool_update.sv]
// ----------------------------------------------------------------------------
// particle_pool_update
// Particle pool with emit, time-step update and slot read commands.
// ----------------------------------------------------------------------------
// One command item in, one result item out, over valid/stall channels.
// Settings are to be written over the APB port only while the block is idle;
// the block itself does not enforce this. After reset the block clears all
// POOL_SIZE slots, one per cycle, and holds o_in_stall high until it is done.
// Emit: states E0 to E3, then DONE; the shared multiplier runs three jitter
// products in turn.
// Read: states R0 and R1, then DONE (one memory read).
// Update: the sequencer visits every slot; an inactive or expiring slot passes
// through U0 and U1, a moving slot through U0 to U3 (two products through the
// shared multiplier), then DONE.
// The next item is taken in the idle state after a command ends.
// The input is stalled while a command is in progress; a new item is taken
// while the previous result still waits in the output register.
// If the receiver stalls, the finished result waits and the block holds
// until the output register frees.
// ----------------------------------------------------------------------------
module particle_pool_update (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  ppu_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output ppu_pkg::t_out_item          o_out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ppu_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ppu_pkg::*;

    localparam int SUM_W = 42;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_E0   = 4'd2;
    localparam logic [3:0] S_E1   = 4'd3;
    localparam logic [3:0] S_E2   = 4'd4;
    localparam logic [3:0] S_E3   = 4'd5;
    localparam logic [3:0] S_R0   = 4'd6;
    localparam logic [3:0] S_R1   = 4'd7;
    localparam logic [3:0] S_U0   = 4'd8;
    localparam logic [3:0] S_U1   = 4'd9;
    localparam logic [3:0] S_U2   = 4'd10;
    localparam logic [3:0] S_U3   = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(POOL_SIZE - 1);

    function automatic logic signed [SUM_W-1:0] shr16(input logic signed [PROD_W-1:0] p);
        return SUM_W'(p >>> 16);
    endfunction

    function automatic logic signed [SUM_W-1:0] ext32(input logic signed [31:0] v);
        return {{(SUM_W-32){v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] r;
        if (v > ext32(32'sh7FFFFFFF)) begin
            r = 32'sh7FFFFFFF;
        end else if (v < ext32(32'sh80000000)) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic t_out_item report(input logic [ADDR_W-1:0] s, input t_slot d);
        t_out_item o;
        o.slot            = SLOT_W'(s);
        o.is_active       = d.active;
        o.out_x           = d.pos_x;
        o.out_y           = d.pos_y;
        o.out_vel_x       = d.vel_x;
        o.out_vel_y       = d.vel_y;
        o.out_begin_scale = d.begin_scale;
        o.out_end_scale   = d.end_scale;
        o.out_color       = d.color;
        o.life_left       = d.life_left;
        o.life_total      = d.life_total;
        o.active_count    = '0;
        return o;
    endfunction

    t_cfg                      cfg;
    logic [3:0]                r_state, n_state;
    logic [ADDR_W-1:0]         r_idx, n_idx;
    logic [ADDR_W-1:0]         r_ptr, n_ptr;
    logic [CNT_W-1:0]          r_count, n_count;
    logic                      r_out_valid, n_out_valid;
    t_in_item                  r_item, n_item;
    t_out_item                 r_res, n_res;
    t_out_item                 r_out, n_out;
    logic [15:0]               r_bs, n_bs;
    logic signed [31:0]        r_vx, n_vx;
    logic signed [31:0]        r_px, n_px;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [SUM_W-1:0]   prod_sh;

    logic                      mem_we, mem_re;
    logic [ADDR_W-1:0]         mem_waddr, mem_raddr;
    t_slot                     mem_wdata, rd;

    logic                      in_accept;
    logic                      out_free;
    logic                      last_slot;
    logic                      read_ok;
    logic signed [SUM_W-1:0]   bs_sum;
    logic signed [15:0]        dj_s, dj_x, dj_y;

    ppu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ppu_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    ppu_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign out_free    = ~r_out_valid | ~i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign last_slot   = (r_idx == LAST_SLOT);
    assign read_ok     = ({22'd0, r_item.slot_index} < 32'(POOL_SIZE));
    assign prod_sh     = shr16(prod);
    assign bs_sum      = {{(SUM_W-16){1'b0}}, cfg.begin_scale} + prod_sh;
    assign dj_s        = {~r_item.jitter_scale[15], r_item.jitter_scale[14:0]};
    assign dj_x        = {~r_item.jitter_vx[15], r_item.jitter_vx[14:0]};
    assign dj_y        = {~r_item.jitter_vy[15], r_item.jitter_vy[14:0]};

    always_comb begin
        unique case (r_state)
            S_E0: begin
                mul_a = {16'd0, cfg.scale_variation};
                mul_b = {{(MUL_B_W-16){dj_s[15]}}, dj_s};
            end
            S_E1: begin
                mul_a = {1'b0, cfg.velocity_spread};
                mul_b = {{(MUL_B_W-16){dj_x[15]}}, dj_x};
            end
            S_E2: begin
                mul_a = {1'b0, cfg.velocity_spread};
                mul_b = {{(MUL_B_W-16){dj_y[15]}}, dj_y};
            end
            S_U1: begin
                mul_a = rd.vel_x;
                mul_b = {1'b0, r_item.time_step};
            end
            S_U2: begin
                mul_a = rd.vel_y;
                mul_b = {1'b0, r_item.time_step};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_ptr       = r_ptr;
        n_count     = r_count;
        n_item      = r_item;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid & i_out_stall;
        n_bs        = r_bs;
        n_vx        = r_vx;
        n_px        = r_px;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = rd;
        mem_re      = 1'b0;
        mem_raddr   = r_idx;

        unique case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                n_idx     = r_idx + 1'b1;
                if (last_slot) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_item  = i_in_item;
                    n_idx   = '0;
                    n_count = '0;
                    case (i_in_item.command)
                        CMD_EMIT:   n_state = S_E0;
                        CMD_UPDATE: n_state = S_U0;
                        CMD_READ:   n_state = S_R0;
                        default: begin
                            n_res   = '0;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_E0: begin
                n_state = S_E1;
            end
            S_E1: begin
                if (bs_sum < 0) begin
                    n_bs = 16'd0;
                end else if (bs_sum > SUM_W'(65535)) begin
                    n_bs = 16'hFFFF;
                end else begin
                    n_bs = bs_sum[15:0];
                end
                n_state = S_E2;
            end
            S_E2: begin
                n_vx    = sat32(ext32(r_item.vel_x) + prod_sh);
                n_state = S_E3;
            end
            S_E3: begin
                mem_we                = 1'b1;
                mem_waddr             = r_ptr;
                mem_wdata.active      = 1'b1;
                mem_wdata.pos_x       = r_item.pos_x;
                mem_wdata.pos_y       = r_item.pos_y;
                mem_wdata.vel_x       = r_vx;
                mem_wdata.vel_y       = sat32(ext32(r_item.vel_y) + prod_sh);
                mem_wdata.begin_scale = r_bs;
                mem_wdata.end_scale   = cfg.end_scale;
                mem_wdata.color       = cfg.emit_color;
                mem_wdata.life_left   = {1'b0, cfg.emit_lifetime};
                mem_wdata.life_total  = cfg.emit_lifetime;
                n_res                 = report(r_ptr, mem_wdata);
                n_ptr                 = (r_ptr == '0) ? LAST_SLOT : r_ptr - 1'b1;
                n_state               = S_DONE;
            end
            S_R0: begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(r_item.slot_index);
                n_state   = S_R1;
            end
            S_R1: begin
                if (read_ok) begin
                    n_res = report(ADDR_W'(r_item.slot_index), rd);
                end else begin
                    n_res      = '0;
                    n_res.slot = r_item.slot_index;
                end
                n_state = S_DONE;
            end
            S_U0: begin
                mem_re  = 1'b1;
                n_state = S_U1;
            end
            S_U1: begin
                if (rd.active && (rd.life_left > 0)) begin
                    n_state = S_U2;
                end else begin
                    if (rd.active) begin
                        mem_we           = 1'b1;
                        mem_wdata.active = 1'b0;
                    end
                    n_idx = r_idx + 1'b1;
                    if (last_slot) begin
                        n_res              = '0;
                        n_res.active_count = r_count;
                        n_state            = S_DONE;
                    end else begin
                        n_state = S_U0;
                    end
                end
            end
            S_U2: begin
                n_px    = sat32(ext32(rd.pos_x) + prod_sh);
                n_state = S_U3;
            end
            S_U3: begin
                mem_we              = 1'b1;
                mem_wdata.pos_x     = r_px;
                mem_wdata.pos_y     = sat32(ext32(rd.pos_y) + prod_sh);
                mem_wdata.life_left = sat32(ext32(rd.life_left)
                                      - {{(SUM_W-24){1'b0}}, r_item.time_step});
                n_count             = r_count + 1'b1;
                n_idx               = r_idx + 1'b1;
                if (last_slot) begin
                    n_res              = '0;
                    n_res.active_count = n_count;
                    n_state            = S_DONE;
                end else begin
                    n_state = S_U0;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_idx       <= '0;
            r_ptr       <= LAST_SLOT;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_ptr       <= n_ptr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_res  <= n_res;
        r_out  <= n_out;
        r_bs   <= n_bs;
        r_vx   <= n_vx;
        r_px   <= n_px;
    end

endmodule

[design/ppu_cfg.sv]
// ----------------------------------------------------------------------------
// ppu_cfg
// APB register file holding the emitter settings.
// ----------------------------------------------------------------------------
module ppu_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ppu_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output ppu_pkg::t_cfg               o_cfg
);
    import ppu_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.begin_scale     <= 16'd256;
            r_cfg.end_scale       <= 16'd0;
            r_cfg.scale_variation <= 16'd0;
            r_cfg.velocity_spread <= 31'd0;
            r_cfg.emit_color      <= 24'hFFFFFF;
            r_cfg.emit_lifetime   <= 31'd65536;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BEGIN_SCALE:     r_cfg.begin_scale     <= pwdata[15:0];
                REG_END_SCALE:       r_cfg.end_scale       <= pwdata[15:0];
                REG_SCALE_VARIATION: r_cfg.scale_variation <= pwdata[15:0];
                REG_VELOCITY_SPREAD: r_cfg.velocity_spread <= pwdata[30:0];
                REG_EMIT_COLOR:      r_cfg.emit_color      <= pwdata[23:0];
                REG_EMIT_LIFETIME:   r_cfg.emit_lifetime   <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BEGIN_SCALE:     prdata = {16'd0, r_cfg.begin_scale};
            REG_END_SCALE:       prdata = {16'd0, r_cfg.end_scale};
            REG_SCALE_VARIATION: prdata = {16'd0, r_cfg.scale_variation};
            REG_VELOCITY_SPREAD: prdata = {1'b0, r_cfg.velocity_spread};
            REG_EMIT_COLOR:      prdata = {8'd0, r_cfg.emit_color};
            REG_EMIT_LIFETIME:   prdata = {1'b0, r_cfg.emit_lifetime};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

[design/ppu_mul.sv]
// ----------------------------------------------------------------------------
// ppu_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ppu_mul (
    input  logic                               i_clk,
    input  logic signed [ppu_pkg::MUL_A_W-1:0] i_a,
    input  logic signed [ppu_pkg::MUL_B_W-1:0] i_b,
    output logic signed [ppu_pkg::PROD_W-1:0]  o_prod
);
    import ppu_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

[design/ppu_store.sv]
// ----------------------------------------------------------------------------
// ppu_store
// Slot memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module ppu_store (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ppu_pkg::ADDR_W-1:0] i_waddr,
    input  ppu_pkg::t_slot             i_wdata,
    input  logic                       i_re,
    input  logic [ppu_pkg::ADDR_W-1:0] i_raddr,
    output ppu_pkg::t_slot             o_rdata
);
    import ppu_pkg::*;

    t_slot mem [POOL_SIZE];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
